// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, disabled while reset is high.
`define ASSERT_CLKRST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check that also runs through reset.
`define ASSERT_CLK(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/hsvrgb_pkg.sv =====
// Package for the HSV to RGB converter: widths, fixed-point constants, stage types.
// No dependencies; imported by every module of the converter.
`timescale 1ns / 1ps

package hsvrgb_pkg;

   localparam int HUE_W    = 13;
   localparam int LEVEL_W  = 8;
   localparam int POS_W    = 11;
   localparam int DIST_W   = 10;
   localparam int VS_W     = 16;
   localparam int PROD_W   = 26;
   localparam int NUM_W    = 27;
   localparam int SCALED_W = 21;
   localparam int RECIP_W  = 23;
   localparam int MUL_W    = SCALED_W + RECIP_W;
   localparam int RECIP_SHIFT = 35;

   localparam logic [HUE_W-1:0] HUE_MAX = 13'd5759;
   localparam int SECTOR_SPAN = 960;
   localparam int PAIR_SPAN   = 1920;
   localparam int SECTORS     = 6;
   // common denominator 255*960, doubled for the half-step rounding
   localparam int ROUND_HALF  = 244800;
   localparam int ROUND_FULL  = 2 * ROUND_HALF;
   // numerator is pre-shifted by 6, leaving a divide by 7650
   localparam int DROP_BITS   = 6;
   // ceil(2^35 / 7650), exact for any 21-bit dividend
   localparam logic [RECIP_W-1:0] RECIP_K = 23'd4491470;

   typedef enum logic [2:0] {
      SEC_RY,
      SEC_YG,
      SEC_GC,
      SEC_CB,
      SEC_BM,
      SEC_MR
   } sector_type;

   typedef struct packed {
      sector_type                sector;
      logic [DIST_W-1:0]         delta;
      logic [VS_W-1:0]           vs;
      logic [LEVEL_W-1:0]        bright;
   } prep_type;

   typedef struct packed {
      logic [SCALED_W-1:0] blue;
      logic [SCALED_W-1:0] green;
      logic [SCALED_W-1:0] red;
   } scaled_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] blue;
      logic [LEVEL_W-1:0] green;
      logic [LEVEL_W-1:0] red;
   } rgb_type;

endpackage

// ===== rtl/hsvrgb_prep.sv =====
// First stage: hue limit, sector and distance from the sector-pair centre, V*S.
// Depends on hsvrgb_pkg.
`timescale 1ns / 1ps

module hsvrgb_prep import hsvrgb_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [HUE_W-1:0]   hue,
   input  logic [LEVEL_W-1:0] sat,
   input  logic [LEVEL_W-1:0] bright,
   output logic               out_valid,
   input  logic               out_ready,
   output prep_type           out_data
);

   logic               valid_ff, valid_in;
   prep_type           data_ff, data_in;
   logic [HUE_W-1:0]   hue_lim;
   logic [2:0]         count;
   logic [HUE_W-1:0]   base;
   logic [POS_W-1:0]   pos;

   assign in_ready = !valid_ff || out_ready;
   assign hue_lim  = (hue > HUE_MAX) ? HUE_MAX : hue;

   always_comb begin
      count = 3'd0;
      for (int k = 1; k < SECTORS; k++) begin
         if (hue_lim >= HUE_W'(k * SECTOR_SPAN)) begin
            count = count + 3'd1;
         end
      end
   end

   always_comb begin
      case (count[2:1])
         2'd0:    base = '0;
         2'd1:    base = HUE_W'(PAIR_SPAN);
         default: base = HUE_W'(2 * PAIR_SPAN);
      endcase
   end

   assign pos = POS_W'(hue_lim - base);

   always_comb begin
      data_in.sector = sector_type'(count);
      if (pos >= POS_W'(SECTOR_SPAN)) begin
         data_in.delta = DIST_W'(pos - POS_W'(SECTOR_SPAN));
      end else begin
         data_in.delta = DIST_W'(POS_W'(SECTOR_SPAN) - pos);
      end
      data_in.vs     = VS_W'(sat) * VS_W'(bright);
      data_in.bright = bright;
   end

   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== rtl/hsvrgb_mix.sv =====
// Second and third stages: chroma and secondary products, per-channel numerator.
// Depends on hsvrgb_pkg.
`timescale 1ns / 1ps

module hsvrgb_mix import hsvrgb_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  prep_type   in_data,
   output logic       out_valid,
   input  logic       out_ready,
   output scaled_type out_data
);

   typedef enum logic [1:0] {
      CH_RED,
      CH_GREEN,
      CH_BLUE
   } chan_type;

   typedef enum logic [1:0] {
      PART_CHROMA,
      PART_SECOND,
      PART_NONE
   } part_type;

   function automatic part_type pick_part(sector_type sec, chan_type ch);
      part_type p;
      case (sec)
         SEC_RY:  p = (ch == CH_RED) ? PART_CHROMA : (ch == CH_GREEN) ? PART_SECOND : PART_NONE;
         SEC_YG:  p = (ch == CH_RED) ? PART_SECOND : (ch == CH_GREEN) ? PART_CHROMA : PART_NONE;
         SEC_GC:  p = (ch == CH_RED) ? PART_NONE : (ch == CH_GREEN) ? PART_CHROMA : PART_SECOND;
         SEC_CB:  p = (ch == CH_RED) ? PART_NONE : (ch == CH_GREEN) ? PART_SECOND : PART_CHROMA;
         SEC_BM:  p = (ch == CH_RED) ? PART_SECOND : (ch == CH_GREEN) ? PART_NONE : PART_CHROMA;
         default: p = (ch == CH_RED) ? PART_CHROMA : (ch == CH_GREEN) ? PART_NONE : PART_SECOND;
      endcase
      return p;
   endfunction

   // b stage
   logic              b_valid_ff, b_valid_in, b_ready;
   sector_type        b_sector_ff;
   logic [PROD_W-1:0] b_px_ff, b_px_in;
   logic [PROD_W-1:0] b_pz_ff, b_pz_in;
   logic [NUM_W-1:0]  b_vterm_ff, b_vterm_in;

   // c stage
   logic              c_valid_ff, c_valid_in, c_ready;
   scaled_type        c_data_ff, c_data_in;

   function automatic logic [SCALED_W-1:0] scaled_num(part_type p, logic [PROD_W-1:0] px,
                                                       logic [PROD_W-1:0] pz,
                                                       logic [NUM_W-1:0] vterm);
      logic [PROD_W-1:0] sub;
      logic [NUM_W-1:0]  z;
      case (p)
         PART_CHROMA: sub = '0;
         PART_SECOND: sub = px;
         default:     sub = pz;
      endcase
      z = vterm - {sub, 1'b0};
      return z[NUM_W-1:DROP_BITS];
   endfunction

   assign c_ready  = !c_valid_ff || out_ready;
   assign b_ready  = !b_valid_ff || c_ready;
   assign in_ready = b_ready;

   assign b_px_in    = PROD_W'(in_data.vs) * PROD_W'(in_data.delta);
   assign b_pz_in    = PROD_W'(in_data.vs) * PROD_W'(SECTOR_SPAN);
   assign b_vterm_in = NUM_W'(in_data.bright) * NUM_W'(ROUND_FULL) + NUM_W'(ROUND_HALF);
   assign b_valid_in = b_ready ? in_valid : b_valid_ff;

   always_comb begin
      c_data_in.red   = scaled_num(pick_part(b_sector_ff, CH_RED), b_px_ff, b_pz_ff, b_vterm_ff);
      c_data_in.green = scaled_num(pick_part(b_sector_ff, CH_GREEN), b_px_ff, b_pz_ff,
                                   b_vterm_ff);
      c_data_in.blue  = scaled_num(pick_part(b_sector_ff, CH_BLUE), b_px_ff, b_pz_ff, b_vterm_ff);
   end

   assign c_valid_in = c_ready ? b_valid_ff : c_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= b_valid_in;
         c_valid_ff <= c_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (b_ready && in_valid) begin
         b_sector_ff <= in_data.sector;
         b_px_ff     <= b_px_in;
         b_pz_ff     <= b_pz_in;
         b_vterm_ff  <= b_vterm_in;
      end
      if (c_ready && b_valid_ff) begin
         c_data_ff <= c_data_in;
      end
   end

   assign out_valid = c_valid_ff;
   assign out_data  = c_data_ff;

endmodule

// ===== rtl/hsvrgb_scale.sv =====
// Last stage: divide each channel numerator by 7650 through a reciprocal multiply.
// Depends on hsvrgb_pkg.
`timescale 1ns / 1ps

module hsvrgb_scale import hsvrgb_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  scaled_type in_data,
   output logic       out_valid,
   input  logic       out_ready,
   output rgb_type    out_data
);

   logic             valid_ff, valid_in;
   rgb_type          data_ff, data_in;
   logic [MUL_W-1:0] prod_red, prod_green, prod_blue;

   assign in_ready = !valid_ff || out_ready;

   assign prod_red   = MUL_W'(in_data.red) * MUL_W'(RECIP_K);
   assign prod_green = MUL_W'(in_data.green) * MUL_W'(RECIP_K);
   assign prod_blue  = MUL_W'(in_data.blue) * MUL_W'(RECIP_K);

   always_comb begin
      data_in.red   = prod_red[RECIP_SHIFT +: LEVEL_W];
      data_in.green = prod_green[RECIP_SHIFT +: LEVEL_W];
      data_in.blue  = prod_blue[RECIP_SHIFT +: LEVEL_W];
   end

   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== rtl/hsv_to_rgb_converter.sv =====
// HSV to RGB converter, top level: prep, mix and scale stages in a four-register pipeline.
// Register order from a req transfer to rsp_tvalid: prep, mix b stage, mix c stage, scale.
// Throughput: one pixel per clock; each stage holds one pixel and moves on when the next frees.
// Reset: synchronous, clears all stage valid bits; req_tready is low while reset is high.
// Depends on hsvrgb_pkg, hsvrgb_prep, hsvrgb_mix, hsvrgb_scale.
`timescale 1ns / 1ps

module hsv_to_rgb_converter import hsvrgb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // hue_sixteenths[12:0], sat_level[20:13], bright_level[28:21]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // red_out[7:0], green_out[15:8], blue_out[23:16]
);

   logic       prep_in_ready;
   logic       prep_valid, mix_ready;
   prep_type   prep_data;
   logic       mix_valid, scale_ready;
   scaled_type mix_data;
   rgb_type    rgb_data;

   assign req_tready = prep_in_ready && !reset;

   hsvrgb_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid && !reset),
      .in_ready  (prep_in_ready),
      .hue       (req_tdata[12:0]),
      .sat       (req_tdata[20:13]),
      .bright    (req_tdata[28:21]),
      .out_valid (prep_valid),
      .out_ready (mix_ready),
      .out_data  (prep_data)
   );

   hsvrgb_mix u_mix (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prep_valid),
      .in_ready  (mix_ready),
      .in_data   (prep_data),
      .out_valid (mix_valid),
      .out_ready (scale_ready),
      .out_data  (mix_data)
   );

   hsvrgb_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mix_valid),
      .in_ready  (scale_ready),
      .in_data   (mix_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rgb_data)
   );

   assign rsp_tdata = rgb_data;

endmodule

// ===== rtl/hsvrgb_checker.sv =====
// Port-level checks for the HSV to RGB converter, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hsvrgb_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [31:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   `ASSERT_CLK(a_reset_empty, clock, reset |=> !rsp_tvalid, "rsp_tvalid high after reset")

   `ASSERT_CLKRST(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "rsp_tvalid dropped before transfer")

   `ASSERT_CLKRST(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata), "rsp_tdata changed while stalled")

   // zero saturation gives grey at the input brightness on rsp_tdata when rsp_tready stays high throughout
   `ASSERT_CLKRST(a_grey, clock, reset, (req_tvalid && req_tready && req_tdata[20:13] == 8'd0 && rsp_tready) ##1 rsp_tready ##1 rsp_tready ##1 rsp_tready |=> rsp_tvalid && rsp_tdata[7:0] == $past(req_tdata[28:21], 4) && rsp_tdata[15:8] == $past(req_tdata[28:21], 4) && rsp_tdata[23:16] == $past(req_tdata[28:21], 4), "grey pixel wrong or late")

endmodule

bind hsv_to_rgb_converter hsvrgb_checker u_checker (.*);
